### rtl/core/cnu_pkg.sv
// cnu_pkg: types, mode codes and controller/datapath interface structs
// for the combinatorial count unit. no dependencies.
`timescale 1ns / 1ps

package cnu_pkg;

   localparam int MAX_FACT_ARG_DEF = 12;

   localparam int MODE_W  = 3;
   localparam int N_W     = 8;
   localparam int M_W     = 5;
   localparam int COUNT_W = 31;
   localparam int ACC_W   = 32;
   localparam int PROD_W  = ACC_W + N_W;
   // shared step counter: power loop index, factorial index, divider step
   localparam int CNT_W   = 5;

   localparam logic [MODE_W-1:0] MODE_VAR_REP  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_VAR      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_COMB     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COMB_REP = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PERM     = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [N_W-1:0]    n;
      logic [M_W-1:0]    m;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               status;
   } rsp_word_type;

   // which argument a factorial loop runs up to
   typedef enum logic [2:0] {
      LIM_N   = 3'd0,
      LIM_NM  = 3'd1,
      LIM_M   = 3'd2,
      LIM_NM1 = 3'd3,
      LIM_N1  = 3'd4
   } lim_sel_type;

   typedef struct packed {
      logic        load;
      logic        pow_mul;
      logic        fact_mul;
      logic        fact_start;
      lim_sel_type lim_sel;
      logic        save_num;
      logic        div_start;
      logic        div_step;
      logic        write_out;
   } cnu_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              err;
      logic              mul_ovf;
      logic              pow_done;
      logic              fact_done;
      logic              div_last;
      logic              out_busy;
   } cnu_status_type;

endpackage

### rtl/core/cnu_datapath.sv
// cnu_datapath: argument checks, shared multiplier, restoring divider and
// output register. depends on cnu_pkg.
`timescale 1ns / 1ps

module cnu_datapath
   import cnu_pkg::*;
#(
   parameter int MAX_FACT_ARG = MAX_FACT_ARG_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  req_word_type   req_word,
   input  cnu_cmd_type    cmd,
   output cnu_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [M_W-1:0]    m_ff, m_in;
   logic              err_ff, err_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  num_ff, num_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   logic              arg_err;
   logic [N_W:0]      nm_sum;
   logic [N_W-1:0]    operand;
   logic [PROD_W-1:0] product;
   logic              ovf;
   logic [N_W-1:0]    lim_full;
   logic [ACC_W:0]    rem_shift;
   logic              rem_ge;

   localparam logic [PROD_W-1:0] COUNT_MAX = {{(PROD_W-COUNT_W){1'b0}}, {COUNT_W{1'b1}}};
   localparam logic [N_W-1:0]    MAX_N     = N_W'(MAX_FACT_ARG);
   localparam logic [N_W:0]      MAX_SUM   = (N_W+1)'(MAX_FACT_ARG + 1);

   // argument checks on the incoming word
   always_comb begin
      nm_sum = {1'b0, req_word.n} + {{(N_W+1-M_W){1'b0}}, req_word.m};
      case (req_word.mode)
         MODE_VAR_REP: arg_err = 1'b0;
         MODE_VAR, MODE_COMB: begin
            arg_err = ({{(N_W-M_W){1'b0}}, req_word.m} > req_word.n) || (req_word.n > MAX_N);
         end
         MODE_COMB_REP: arg_err = (req_word.n == '0) || (nm_sum > MAX_SUM);
         MODE_PERM:     arg_err = req_word.n > MAX_N;
         default:       arg_err = 1'b1;
      endcase
   end

   // only the power mode multiplies by n, every other mode by the loop index
   assign operand = (mode_ff == MODE_VAR_REP) ? n_ff : {{(N_W-CNT_W){1'b0}}, cnt_ff};
   assign product = {{N_W{1'b0}}, acc_ff} * {{ACC_W{1'b0}}, operand};
   assign ovf     = product > COUNT_MAX;

   always_comb begin
      case (cmd.lim_sel)
         LIM_N:   lim_full = n_ff;
         LIM_NM:  lim_full = n_ff - {{(N_W-M_W){1'b0}}, m_ff};
         LIM_M:   lim_full = {{(N_W-M_W){1'b0}}, m_ff};
         LIM_NM1: lim_full = n_ff + {{(N_W-M_W){1'b0}}, m_ff} - N_W'(1);
         LIM_N1:  lim_full = n_ff - N_W'(1);
         default: lim_full = n_ff;
      endcase
   end

   assign rem_shift = {rem_ff, num_ff[ACC_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, acc_ff};

   always_comb begin
      mode_in      = mode_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         mode_in = req_word.mode;
         n_in    = req_word.n;
         m_in    = req_word.m;
         err_in  = arg_err;
         acc_in  = ACC_W'(1);
         cnt_in  = '0;
      end
      if (cmd.pow_mul || cmd.fact_mul) begin
         acc_in = product[ACC_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cmd.pow_mul && ovf) begin
            err_in = 1'b1;
         end
      end
      if (cmd.save_num) begin
         num_in = acc_ff;
         acc_in = ACC_W'(1);
      end
      if (cmd.fact_start) begin
         cnt_in = CNT_W'(2);
         // arguments are in range here, the low bits carry the whole value
         lim_in = lim_full[CNT_W-1:0];
      end
      if (cmd.div_start) begin
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_shift[ACC_W-1:0] - acc_ff : rem_shift[ACC_W-1:0];
         num_in = {num_ff[ACC_W-2:0], rem_ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.write_out) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_in.count  = '0;
            rsp_in.status = 1'b1;
         end else if (mode_ff == MODE_VAR_REP || mode_ff == MODE_PERM) begin
            rsp_in.count  = acc_ff[COUNT_W-1:0];
            rsp_in.status = 1'b0;
         end else begin
            rsp_in.count  = num_ff[COUNT_W-1:0];
            rsp_in.status = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      n_ff    <= n_in;
      m_ff    <= m_in;
      err_ff  <= err_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      lim_ff  <= lim_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      status.mode      = mode_ff;
      status.err       = err_ff;
      status.mul_ovf   = ovf;
      status.pow_done  = cnt_ff == m_ff;
      status.fact_done = cnt_ff > lim_ff;
      // counter wraps after 2**CNT_W steps, one per quotient bit
      status.div_last  = &cnt_ff;
      status.out_busy  = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/core/cnu_ctrl.sv
// cnu_ctrl: sequencer for the power loop, factorial loops and division.
// depends on cnu_pkg.
`timescale 1ns / 1ps

module cnu_ctrl
   import cnu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  cnu_status_type status,
   output cnu_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SETUP = 8'b0000_0010,
      ST_POW   = 8'b0000_0100,
      ST_FNUM  = 8'b0000_1000,
      ST_FDEN  = 8'b0001_0000,
      ST_FMUL  = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.lim_sel = LIM_N;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.err) begin
               state_in = ST_DONE;
            end else if (status.mode == MODE_VAR_REP) begin
               state_in = ST_POW;
            end else begin
               cmd.fact_start = 1'b1;
               cmd.lim_sel    = (status.mode == MODE_COMB_REP) ? LIM_NM1 : LIM_N;
               state_in       = ST_FNUM;
            end
         end
         ST_POW: begin
            if (status.pow_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.pow_mul = 1'b1;
               if (status.mul_ovf) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FNUM: begin
            if (!status.fact_done) begin
               cmd.fact_mul = 1'b1;
            end else if (status.mode == MODE_PERM) begin
               state_in = ST_DONE;
            end else begin
               cmd.save_num   = 1'b1;
               cmd.fact_start = 1'b1;
               cmd.lim_sel    = (status.mode == MODE_COMB_REP) ? LIM_N1 : LIM_NM;
               state_in       = ST_FDEN;
            end
         end
         ST_FDEN: begin
            if (!status.fact_done) begin
               cmd.fact_mul = 1'b1;
            end else if (status.mode == MODE_VAR) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               // keep the partial denominator and multiply on by m!
               cmd.fact_start = 1'b1;
               cmd.lim_sel    = LIM_M;
               state_in       = ST_FMUL;
            end
         end
         ST_FMUL: begin
            if (!status.fact_done) begin
               cmd.fact_mul = 1'b1;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.write_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

### rtl/core/combinatorial_count_unit.sv
// channel  direction  word           handshake
// req      in         req_word_type  req_valid / req_stall
// rsp      out        rsp_word_type  rsp_valid / rsp_stall
//
// one word at a time: an argument error skips the loops, a
// power runs one multiply per exponent step, and a combination runs
// up to three factorial loops on the shared multiplier, then a 32-step
// restoring divider. reset is synchronous and clears the sequencer and the
// output valid. the result sits in an output register; a stalled rsp holds
// the sequencer in its final state until the register frees up.
// top level, depends on cnu_pkg, cnu_ctrl and cnu_datapath.
`timescale 1ns / 1ps

module combinatorial_count_unit
   import cnu_pkg::*;
#(
   parameter int MAX_FACT_ARG = MAX_FACT_ARG_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   cnu_cmd_type    cmd;
   cnu_status_type status;

   cnu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cnu_datapath #(
      .MAX_FACT_ARG (MAX_FACT_ARG)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
